### rtl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Types and constants shared by the TCP send window and retransmit engine.
// ----------------------------------------------------------------------------
package tsw_pkg;

	localparam int SEND_BUF_BYTES = 4096;
	localparam int MAX_SEG_BYTES  = 512;
	localparam int MAX_RES        = 8;

	localparam int RING_W = $clog2(SEND_BUF_BYTES);
	localparam int BLEN_W = RING_W + 1;
	localparam int SLEN_W = 10;
	localparam int CNT_W  = $clog2(MAX_RES) + 1;
	localparam int IDX_W  = $clog2(MAX_RES);

	localparam logic [7:0] FLAGS_DATA = 8'h18;
	localparam logic [7:0] FLAGS_RST  = 8'h14;

	localparam logic [CNT_W-1:0]  RES_CAP  = CNT_W'(MAX_RES);
	localparam logic [SLEN_W-1:0] SEG_CAP  = SLEN_W'(MAX_SEG_BYTES);
	localparam logic [BLEN_W:0]   BUF_CAP  = (BLEN_W+1)'(SEND_BUF_BYTES);

	localparam logic [15:0] RTO_RESET   = 16'd100;
	localparam logic [3:0]  LIMIT_RESET = 4'd5;

	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0,
		OP_QUEUE = 3'd1,
		OP_FLUSH = 3'd2,
		OP_ACK   = 3'd3,
		OP_RETX  = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_RST    = 2'd2
	} kind_e;

	typedef enum logic {
		REG_RTO   = 1'b0,
		REG_LIMIT = 1'b1
	} reg_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FLUSH,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] seq_value;
		logic [12:0] byte_count;
		logic [15:0] peer_window;
		logic [31:0] rcv_next;
		logic [31:0] now_ticks;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        status;
		logic [7:0]  tcp_flags;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [11:0] buffer_offset;
		logic [9:0]  seg_length;
		logic [31:0] rto_deadline;
		logic        is_open;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] rto_ticks;
		logic [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic flush;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_flush;
		logic flush_go;
		logic emit_last;
	} ctl_sts_t;

endpackage

### rtl/tsw_ctrl.sv
// ----------------------------------------------------------------------------
// tsw_ctrl
// Sequencer that steps one word through execute, optional flush and emit phases.
// ----------------------------------------------------------------------------
module tsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output tsw_pkg::ctl_cmd_t cmd,
	input  tsw_pkg::ctl_sts_t sts
);
	import tsw_pkg::*;

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = sts.need_flush ? ST_FLUSH : ST_EMIT;
			end
			ST_FLUSH: begin
				if (!sts.flush_go) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.emit_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.exec  = (state_q == ST_EXEC);
		cmd.flush = (state_q == ST_FLUSH);
		cmd.emit  = (state_q == ST_EMIT);
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_EXEC))
		else $error("accepted word did not enter execute");

endmodule

### rtl/tsw_dp.sv
// ----------------------------------------------------------------------------
// tsw_dp
// Connection state, segment cutting, retransmit backoff and result buffer.
// ----------------------------------------------------------------------------
module tsw_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tsw_pkg::cfg_t      cfg,
	input  tsw_pkg::in_word_t  req,
	input  tsw_pkg::ctl_cmd_t  cmd,
	output tsw_pkg::ctl_sts_t  sts,
	output tsw_pkg::out_word_t rsp,
	output logic               strobe
);
	import tsw_pkg::*;

	in_word_t item_q;
	logic [RING_W-1:0] ring_q;
	logic [BLEN_W-1:0] blen_q;
	logic [31:0] una_q;
	logic [31:0] nxt_q;
	logic [3:0]  retry_q;
	logic [31:0] dl_q;
	logic        est_q;
	logic [31:0] end_q;
	logic        status_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] eidx_q;

	logic [1:0]        ent_kind_q [MAX_RES];
	logic [31:0]       ent_seq_q  [MAX_RES];
	logic [RING_W-1:0] ent_off_q  [MAX_RES];
	logic [SLEN_W-1:0] ent_len_q  [MAX_RES];

	out_word_t out_q;
	logic      strobe_q;

	logic [31:0] rto_ext;
	logic [31:0] dl_base;

	logic              ack_adv;
	logic [31:0]       ack_diff;
	logic [BLEN_W-1:0] ack_bytes;
	logic [BLEN_W-1:0] ack_blen;
	logic [31:0]       ack_nxt;
	logic [BLEN_W:0]   q_sum;
	logic              q_reject;

	logic              rx_go;
	logic [31:0]       rx_inflight;
	logic [SLEN_W-1:0] rx_chunk;
	logic [3:0]        rx_rc;
	logic              rx_rst;
	logic [31:0]       rx_dl;

	logic [31:0]       fl_flight;
	logic [31:0]       fl_unsent;
	logic [16:0]       fl_winleft;
	logic [SLEN_W-1:0] fl_us;
	logic [SLEN_W-1:0] fl_chunk;
	logic [31:0]       fl_nxt;
	logic              fl_go;

	logic [CNT_W-1:0] nres_m1;
	logic             em_last;

	assign rto_ext = {16'd0, cfg.rto_ticks};
	assign dl_base = item_q.now_ticks + rto_ext;

	always_comb begin
		ack_adv   = item_q.seq_value > una_q;
		ack_diff  = item_q.seq_value - una_q;
		ack_bytes = (ack_diff > {{(32-BLEN_W){1'b0}}, blen_q}) ? blen_q : ack_diff[BLEN_W-1:0];
		ack_blen  = blen_q - ack_bytes;
		ack_nxt   = (nxt_q < item_q.seq_value) ? item_q.seq_value : nxt_q;
		q_sum     = {1'b0, blen_q} + {1'b0, item_q.byte_count};
		q_reject  = !est_q || (item_q.byte_count == '0) || (q_sum > BUF_CAP);
	end

	always_comb begin
		rx_go       = est_q && (nxt_q > una_q);
		rx_inflight = nxt_q - una_q;
		rx_chunk    = (rx_inflight < {{(32-SLEN_W){1'b0}}, SEG_CAP}) ?
		              rx_inflight[SLEN_W-1:0] : SEG_CAP;
		rx_rc       = retry_q + 4'd1;
		rx_rst      = (rx_rc >= cfg.retry_limit) || (rx_rc == 4'd0);
		rx_dl       = item_q.now_ticks + (rto_ext << (rx_rc - 4'd1));
	end

	always_comb begin
		fl_flight  = nxt_q - una_q;
		fl_unsent  = end_q - nxt_q;
		fl_winleft = {1'b0, item_q.peer_window} - fl_flight[16:0];
		fl_us      = (fl_unsent >= {{(32-SLEN_W){1'b0}}, SEG_CAP}) ?
		             SEG_CAP : fl_unsent[SLEN_W-1:0];
		fl_chunk   = (fl_winleft < {{(17-SLEN_W){1'b0}}, fl_us}) ?
		             fl_winleft[SLEN_W-1:0] : fl_us;
		fl_nxt     = nxt_q + {{(32-SLEN_W){1'b0}}, fl_chunk};
		fl_go      = est_q && (cnt_q < RES_CAP) && (nxt_q < end_q) &&
		             (fl_flight < {16'd0, item_q.peer_window}) && (fl_chunk != '0);
	end

	always_comb begin
		nres_m1 = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
		em_last = ({1'b0, eidx_q} == nres_m1);
	end

	assign sts.need_flush = (item_q.operation == OP_FLUSH) ||
	                        ((item_q.operation == OP_ACK) && ack_adv);
	assign sts.flush_go   = fl_go;
	assign sts.emit_last  = em_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q   <= '0;
			blen_q   <= '0;
			una_q    <= '0;
			nxt_q    <= '0;
			retry_q  <= '0;
			dl_q     <= '0;
			est_q    <= 1'b0;
			cnt_q    <= '0;
			eidx_q   <= '0;
			status_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				cnt_q    <= '0;
				eidx_q   <= '0;
				status_q <= 1'b0;
			end
			if (cmd.exec) begin
				end_q <= ((item_q.operation == OP_ACK) && ack_adv) ?
				         item_q.seq_value + {{(32-BLEN_W){1'b0}}, ack_blen} :
				         una_q + {{(32-BLEN_W){1'b0}}, blen_q};
				case (item_q.operation)
					OP_OPEN: begin
						una_q   <= item_q.seq_value;
						nxt_q   <= item_q.seq_value;
						ring_q  <= '0;
						blen_q  <= '0;
						retry_q <= '0;
						est_q   <= 1'b1;
					end
					OP_QUEUE: begin
						if (q_reject) begin
							status_q <= 1'b1;
						end else begin
							blen_q <= q_sum[BLEN_W-1:0];
						end
					end
					OP_ACK: begin
						if (ack_adv) begin
							ring_q <= ring_q + ack_bytes[RING_W-1:0];
							blen_q <= ack_blen;
							una_q  <= item_q.seq_value;
							nxt_q  <= ack_nxt;
							if (ack_blen == '0) begin
								retry_q <= '0;
							end else if (item_q.seq_value < ack_nxt) begin
								dl_q <= dl_base;
							end
						end
					end
					OP_RETX: begin
						if (rx_go) begin
							if (blen_q == '0) begin
								una_q   <= nxt_q;
								retry_q <= '0;
							end else begin
								ent_kind_q[0] <= KIND_DATA;
								ent_seq_q[0]  <= una_q;
								ent_off_q[0]  <= ring_q;
								ent_len_q[0]  <= rx_chunk;
								retry_q       <= rx_rc;
								if (rx_rst) begin
									ent_kind_q[1] <= KIND_RST;
									ent_seq_q[1]  <= nxt_q;
									ent_off_q[1]  <= '0;
									ent_len_q[1]  <= '0;
									est_q         <= 1'b0;
									cnt_q         <= CNT_W'(2);
								end else begin
									dl_q  <= rx_dl;
									cnt_q <= CNT_W'(1);
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.flush && fl_go) begin
				ent_kind_q[cnt_q[IDX_W-1:0]] <= KIND_DATA;
				ent_seq_q[cnt_q[IDX_W-1:0]]  <= nxt_q;
				ent_off_q[cnt_q[IDX_W-1:0]]  <= ring_q + fl_flight[RING_W-1:0];
				ent_len_q[cnt_q[IDX_W-1:0]]  <= fl_chunk;
				nxt_q <= fl_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (una_q < fl_nxt) begin
					dl_q <= dl_base;
				end
			end
			if (cmd.emit) begin
				eidx_q <= eidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.rto_deadline <= dl_q;
			out_q.is_open      <= est_q;
			out_q.last         <= em_last;
			if (cnt_q == '0) begin
				out_q.kind          <= KIND_STATUS;
				out_q.status        <= status_q;
				out_q.tcp_flags     <= '0;
				out_q.seg_seq       <= '0;
				out_q.seg_ack       <= '0;
				out_q.buffer_offset <= '0;
				out_q.seg_length    <= '0;
			end else begin
				out_q.kind          <= ent_kind_q[eidx_q];
				out_q.status        <= 1'b0;
				out_q.tcp_flags     <= (ent_kind_q[eidx_q] == KIND_RST) ? FLAGS_RST : FLAGS_DATA;
				out_q.seg_seq       <= ent_seq_q[eidx_q];
				out_q.seg_ack       <= item_q.rcv_next;
				out_q.buffer_offset <= ent_off_q[eidx_q];
				out_q.seg_length    <= ent_len_q[eidx_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	assign rsp    = out_q;
	assign strobe = strobe_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_CAP)
		else $error("result count above cap");

	a_buf_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, blen_q} <= BUF_CAP)
		else $error("buffered length above buffer size");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && out_q.kind == KIND_DATA) |->
		(out_q.seg_length != '0 && out_q.seg_length <= SEG_CAP))
		else $error("data segment length out of range");

	a_flush_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && fl_go) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("flush step did not record a segment");

endmodule

### rtl/tcp_send_window_retransmit.sv
// ----------------------------------------------------------------------------
// tcp_send_window_retransmit
// Send-side TCP window engine that issues segment descriptors.
// ----------------------------------------------------------------------------
// An accepted word passes an execute step, then, for a flush or an advancing ack, one flush
// step per data segment cut (up to eight) plus one closing check, then the emit phase.
// Each result word and its strobe are registered from the emit phase.
// Results are one per cycle and cannot be stalled; a new word is taken at the first edge with busy low.
// Reset clears the connection state to closed and loads default timer values.
module tcp_send_window_retransmit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  tsw_pkg::in_word_t  req,
	output logic               strobe,
	output tsw_pkg::out_word_t rsp
);
	import tsw_pkg::*;

	cfg_t     cfg_q;
	ctl_cmd_t cmd;
	ctl_sts_t sts;
	reg_e     reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_e'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto_ticks   <= RTO_RESET;
			cfg_q.retry_limit <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_RTO:   cfg_q.rto_ticks   <= pwdata[15:0];
				REG_LIMIT: cfg_q.retry_limit <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RTO:   prdata = {16'd0, cfg_q.rto_ticks};
			REG_LIMIT: prdata = {28'd0, cfg_q.retry_limit};
			default:   prdata = '0;
		endcase
	end

	tsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	tsw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.strobe (strobe)
	);

endmodule

### test/tcp_send_window_retransmit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_send_window_retransmit_tb
// Drives open, queue, flush, ack and retransmit commands into the send window
// engine and checks every result word against a cycle-free prediction of the
// window, ring and retransmit timer. Runs a short directed sequence, then
// random connection traffic under several timer settings and idle patterns.
// ----------------------------------------------------------------------------
module tcp_send_window_retransmit_tb;
	import tsw_pkg::*;

	localparam logic [2:0] OP_UNDEF_LO = 3'd5;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	localparam int SETTLE_CYCLES = 25;
	localparam int WORDS_PER_PHASE = 19;

	typedef enum logic [1:0] {
		ACK_ABS,
		ACK_FROM_UNA,
		ACK_FROM_NXT
	} anchor_e;

	typedef struct {
		in_word_t w;
		anchor_e  anchor;
	} job_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	in_word_t    req;
	logic        strobe;
	out_word_t   rsp;

	tcp_send_window_retransmit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.strobe  (strobe),
		.rsp     (rsp)
	);

	// Predicted connection state and timer settings.
	logic [11:0] ring_base;
	logic [12:0] buf_len;
	logic [31:0] una;
	logic [31:0] nxt;
	logic [3:0]  retries;
	logic [31:0] deadline;
	logic        est;
	logic [15:0] rto;
	logic [3:0]  limit;

	out_word_t step_q[$];
	out_word_t due_words[$];
	job_t      pending_q[$];
	bit        item_taken;
	int        gap_pct;
	int        errors;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string what);
		errors++;
		if (errors <= 100) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	function automatic void note_word(input kind_e k, input logic st, input logic [7:0] flags,
			input logic [31:0] seq, input logic [31:0] ack, input logic [11:0] off,
			input logic [9:0] len);
		out_word_t o;
		o = '0;
		o.kind = k;
		o.status = st;
		o.tcp_flags = flags;
		o.seg_seq = seq;
		o.seg_ack = ack;
		o.buffer_offset = off;
		o.seg_length = len;
		if (step_q.size() < MAX_RES) begin
			step_q.push_back(o);
		end
	endfunction

	function automatic void cut_segments(input logic [31:0] window, input logic [31:0] rcv,
			input logic [31:0] now);
		logic [31:0] end_seq, flight, unsent, win_left, chunk;
		int sent;
		sent = 0;
		while (est && sent < MAX_RES) begin
			end_seq = una + 32'(buf_len);
			if (!(nxt < end_seq)) break;
			flight = nxt - una;
			if (flight >= window) break;
			win_left = window - flight;
			unsent = end_seq - nxt;
			chunk = MAX_SEG_BYTES;
			if (chunk > unsent) chunk = unsent;
			if (chunk > win_left) chunk = win_left;
			if (chunk == 0) break;
			note_word(KIND_DATA, 1'b0, FLAGS_DATA, nxt, rcv, ring_base + flight[11:0],
				chunk[9:0]);
			sent++;
			nxt = nxt + chunk;
			if (una < nxt) begin
				deadline = now + 32'(rto);
			end
		end
	endfunction

	function automatic void window_step(input in_word_t w);
		logic [31:0] acked, chunk, inflight;
		logic        rejected;
		int          k;
		step_q.delete();
		rejected = 1'b0;
		case (w.operation)
			OP_OPEN: begin
				una = w.seq_value;
				nxt = w.seq_value;
				ring_base = '0;
				buf_len = '0;
				retries = '0;
				est = 1'b1;
			end
			OP_QUEUE: begin
				if (!est || w.byte_count == 0 ||
						32'(buf_len) + 32'(w.byte_count) > SEND_BUF_BYTES) begin
					rejected = 1'b1;
				end else begin
					buf_len = buf_len + w.byte_count;
				end
			end
			OP_FLUSH: begin
				cut_segments(32'(w.peer_window), w.rcv_next, w.now_ticks);
			end
			OP_ACK: begin
				if (w.seq_value > una) begin
					acked = w.seq_value - una;
					if (acked > 32'(buf_len)) acked = 32'(buf_len);
					ring_base = ring_base + acked[11:0];
					buf_len = buf_len - acked[12:0];
					una = w.seq_value;
					if (nxt < una) nxt = una;
					if (buf_len == 0) begin
						retries = '0;
					end else if (una < nxt) begin
						deadline = w.now_ticks + 32'(rto);
					end
					cut_segments(32'(w.peer_window), w.rcv_next, w.now_ticks);
				end
			end
			OP_RETX: begin
				if (est && nxt > una) begin
					if (buf_len == 0) begin
						una = nxt;
						retries = '0;
					end else begin
						chunk = MAX_SEG_BYTES;
						inflight = nxt - una;
						if (chunk > inflight) chunk = inflight;
						note_word(KIND_DATA, 1'b0, FLAGS_DATA, una, w.rcv_next, ring_base,
							chunk[9:0]);
						retries = retries + 4'd1;
						if (retries >= limit || retries == 0) begin
							note_word(KIND_RST, 1'b0, FLAGS_RST, nxt, w.rcv_next, '0, '0);
							est = 1'b0;
						end else begin
							deadline = w.now_ticks + 32'(rto) * (32'd1 << (retries - 4'd1));
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (step_q.size() == 0) begin
			note_word(KIND_STATUS, rejected, 8'h00, '0, '0, '0, '0);
		end
		for (k = 0; k < step_q.size(); k++) begin
			step_q[k].rto_deadline = deadline;
			step_q[k].is_open = est;
			step_q[k].last = (k == step_q.size() - 1);
			due_words.push_back(step_q[k]);
		end
	endfunction

	always @(negedge clk) begin : feed
		job_t     job;
		in_word_t word;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			item_taken = 1'b0;
			if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				job = pending_q.pop_front();
				word = job.w;
				if (job.anchor == ACK_FROM_UNA) begin
					word.seq_value = una + job.w.seq_value;
				end else if (job.anchor == ACK_FROM_NXT) begin
					word.seq_value = nxt + job.w.seq_value;
				end
				req <= word;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		out_word_t want;
		if (arst_n) begin
			if (strobe) begin
				if (due_words.size() == 0) begin
					report($sformatf("unexpected word %h", rsp));
				end else begin
					want = due_words.pop_front();
					check_field("kind", 32'(rsp.kind), 32'(want.kind));
					check_field("status", 32'(rsp.status), 32'(want.status));
					check_field("tcp_flags", 32'(rsp.tcp_flags), 32'(want.tcp_flags));
					check_field("seg_seq", rsp.seg_seq, want.seg_seq);
					check_field("seg_ack", rsp.seg_ack, want.seg_ack);
					check_field("buffer_offset", 32'(rsp.buffer_offset),
						32'(want.buffer_offset));
					check_field("seg_length", 32'(rsp.seg_length), 32'(want.seg_length));
					check_field("rto_deadline", rsp.rto_deadline, want.rto_deadline);
					check_field("is_open", 32'(rsp.is_open), 32'(want.is_open));
					check_field("last", 32'(rsp.last), 32'(want.last));
				end
			end
			if (start && !busy) begin
				window_step(req);
				item_taken = 1'b1;
			end
		end
	end

	task automatic push_job(input logic [2:0] op, input logic [31:0] seq,
			input logic [12:0] cnt, input logic [15:0] win, input logic [31:0] rcv,
			input logic [31:0] now, input anchor_e anchor);
		job_t j;
		j.w.operation = op;
		j.w.seq_value = seq;
		j.w.byte_count = cnt;
		j.w.peer_window = win;
		j.w.rcv_next = rcv;
		j.w.now_ticks = now;
		j.anchor = anchor;
		pending_q.push_back(j);
	endtask

	task automatic write_reg(input reg_e r, input logic [31:0] v);
		logic [31:0] mask;
		mask = (r == REG_RTO) ? 32'h0000_FFFF : 32'h0000_000F;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {r, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (r == REG_RTO) begin
			rto = v[15:0];
		end else begin
			limit = v[3:0];
		end
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (v & mask)) begin
			report($sformatf("register %0d reads %h, wrote %h", r, prdata, v));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic settle();
		while (pending_q.size() != 0 || start || due_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int          p, i, pick;
		logic [2:0]  op;
		logic [31:0] seq;
		logic [12:0] cnt;
		logic [15:0] win;
		anchor_e     anchor;
		logic [31:0] tick;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_taken = 1'b0;
		gap_pct = 0;
		errors = 0;
		ring_base = '0;
		buf_len = '0;
		una = '0;
		nxt = '0;
		retries = '0;
		deadline = '0;
		est = 1'b0;
		rto = RTO_RESET;
		limit = LIMIT_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Closed connection: queue is rejected, others leave only a status word.
		push_job(OP_QUEUE, '0, 13'd100, 16'd1000, '0, '0, ACK_ABS);
		push_job(OP_RETX, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, '0, ACK_ABS);
		push_job(OP_FLUSH, '0, '0, 16'hFFFF, '0, 32'd100, ACK_ABS);
		push_job(OP_ACK, 32'hFFFF_FFFF, '0, 16'hFFFF, '0, 32'd200, ACK_ABS);
		push_job(OP_UNDEF_LO, 32'h1234_5678, 13'd7, 16'd9, '0, '0, ACK_ABS);
		push_job(OP_UNDEF_HI, 32'hFFFF_FFFF, 13'h1FFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, ACK_ABS);
		// Open, fill the whole buffer, then send it under a narrow and a wide window.
		push_job(OP_OPEN, 32'h1000_0000, '0, '0, '0, '0, ACK_ABS);
		push_job(OP_QUEUE, '0, 13'd0, '0, '0, '0, ACK_ABS);
		push_job(OP_QUEUE, '0, 13'd4096, '0, '0, '0, ACK_ABS);
		push_job(OP_QUEUE, '0, 13'd1, '0, '0, '0, ACK_ABS);
		push_job(OP_FLUSH, '0, '0, 16'd1000, 32'h1234_5678, 32'd1000, ACK_ABS);
		push_job(OP_FLUSH, '0, '0, 16'd0, 32'h1234_5678, 32'd1100, ACK_ABS);
		push_job(OP_FLUSH, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, ACK_ABS);
		push_job(OP_RETX, '0, '0, 16'hFFFF, 32'h0000_0001, 32'd5000, ACK_ABS);
		push_job(OP_ACK, 32'd0, '0, 16'hFFFF, '0, 32'd5100, ACK_FROM_UNA);
		push_job(OP_ACK, 32'd700, '0, 16'hFFFF, 32'h0000_0002, 32'd5200, ACK_FROM_UNA);
		// Backoff doubles each time until the retry limit sends a reset.
		for (i = 0; i < 4; i++) begin
			push_job(OP_RETX, '0, '0, 16'hFFFF, 32'h0000_0003, 32'd6000 + i, ACK_ABS);
		end
		push_job(OP_ACK, 32'd0, '0, 16'hFFFF, '0, 32'd7000, ACK_FROM_NXT);
		push_job(OP_OPEN, 32'h0000_0000, '0, '0, '0, '0, ACK_ABS);
		push_job(OP_OPEN, 32'hFFFF_FFFF, '0, '0, '0, '0, ACK_ABS);
		settle();

		// A zero retry limit resets on the first retransmission.
		write_reg(REG_LIMIT, 32'd0);
		push_job(OP_OPEN, 32'd500, '0, '0, '0, '0, ACK_ABS);
		push_job(OP_QUEUE, '0, 13'd600, '0, '0, '0, ACK_ABS);
		push_job(OP_FLUSH, '0, '0, 16'hFFFF, 32'd77, 32'd10, ACK_ABS);
		push_job(OP_RETX, '0, '0, 16'hFFFF, 32'd78, 32'd20, ACK_ABS);
		settle();

		for (p = 0; p < 5; p++) begin
			case (p)
				0: begin
					write_reg(REG_RTO, 32'd1);
					write_reg(REG_LIMIT, 32'd1);
					gap_pct = 0;
				end
				1: begin
					write_reg(REG_RTO, 32'd65535);
					write_reg(REG_LIMIT, 32'd15);
					gap_pct = 49;
				end
				2: begin
					write_reg(REG_RTO, $urandom_range(1, 65535));
					write_reg(REG_LIMIT, $urandom_range(1, 15));
					gap_pct = 10;
				end
				3: begin
					write_reg(REG_RTO, 32'd100);
					write_reg(REG_LIMIT, 32'd3);
					gap_pct = 0;
				end
				default: begin
					write_reg(REG_RTO, $urandom_range(1, 65535));
					write_reg(REG_LIMIT, $urandom_range(1, 15));
					gap_pct = 49;
				end
			endcase
			tick = $urandom;
			for (i = 0; i < WORDS_PER_PHASE; i++) begin
				seq = '0;
				cnt = '0;
				anchor = ACK_ABS;
				tick = tick + $urandom_range(0, 300);
				case ($urandom_range(7))
					0: win = 16'd0;
					1: win = $urandom_range(1, 600);
					2: win = 16'hFFFF;
					default: win = $urandom_range(65535);
				endcase
				pick = $urandom_range(99);
				if (i == 0 || pick < 6) begin
					op = OP_OPEN;
					case ($urandom_range(3))
						0: seq = 32'hFFFF_F000 + $urandom_range(4095);
						1: seq = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
						default: seq = $urandom;
					endcase
				end else if (pick < 32) begin
					op = OP_QUEUE;
					case ($urandom_range(9))
						0: cnt = 13'd0;
						1: cnt = 13'd4096;
						2: cnt = $urandom_range(4096);
						default: cnt = $urandom_range(1, 1200);
					endcase
				end else if (pick < 55) begin
					op = OP_FLUSH;
				end else if (pick < 82) begin
					op = OP_ACK;
					case ($urandom_range(9))
						0: seq = $urandom;
						1, 2: anchor = ACK_FROM_NXT;
						3: anchor = ACK_FROM_UNA;
						default: begin
							anchor = ACK_FROM_UNA;
							seq = $urandom_range(1, 1500);
						end
					endcase
				end else begin
					op = OP_RETX;
				end
				push_job(op, seq, cnt, win, $urandom, $urandom_range(3) == 0 ? $urandom : tick,
					anchor);
			end
			settle();
		end

		if (due_words.size() != 0) begin
			report($sformatf("%0d words never arrived", due_words.size()));
		end
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/tsw_pkg.sv
rtl/tsw_ctrl.sv
rtl/tsw_dp.sv
rtl/tcp_send_window_retransmit.sv
test/tcp_send_window_retransmit_tb.sv
